@@ rtl/core/itp_pkg.sv @@
// shared types, character codes and priority helpers for the infix to postfix converter
package itp_pkg;

    // input word: one character of the infix expression
    typedef struct packed {
        logic [7:0] symbol;
        logic       expr_last;
    } t_in_word;

    // output word: one postfix result
    typedef struct packed {
        logic [7:0] out_char;
        logic       has_char;
        logic       run_last;
        logic       expr_done;
        logic [1:0] error_code;
    } t_out_word;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN   = 2'd1;
    localparam logic [1:0] ERR_UNMATCHED = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd3;

    // character codes
    localparam logic [7:0] CH_OPEN    = 8'h28;
    localparam logic [7:0] CH_CLOSE   = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_CARET   = 8'h5E;

    // token classes seen by the back end
    typedef enum logic [2:0] {
        TK_ALNUM,
        TK_OPEN,
        TK_CLOSE,
        TK_OPER,
        TK_UNKNOWN
    } t_tok_kind;

    // classified word passed from front to back
    typedef struct packed {
        t_tok_kind  kind;
        logic [7:0] symbol;
        logic       last;
    } t_token;

    // back end sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TOP,
        S_FLUSH,
        S_FTOP,
        S_END
    } t_back_state;

    // operator priority, zero for anything that is not an operator or open paren
    function automatic logic [2:0] prio_of(input logic [7:0] c);
        logic [2:0] p;
        unique case (c) inside
            CH_OPEN:                      p = 3'd1;
            CH_PLUS, CH_MINUS:            p = 3'd2;
            CH_STAR, CH_SLASH, CH_PERCENT: p = 3'd3;
            CH_CARET:                     p = 3'd4;
            default:                      p = 3'd0;
        endcase
        return p;
    endfunction

    // stack top leaves before the incoming operator; caret is right-associative
    function automatic logic pops_over(input logic [7:0] top, input logic [7:0] tok);
        logic r;
        if (top == CH_CARET && tok == CH_CARET) begin
            r = 1'b0;
        end else begin
            r = (prio_of(top) >= prio_of(tok));
        end
        return r;
    endfunction

endpackage

@@ rtl/core/itp_ram.sv @@
// generic single write port ram with registered read
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/itp_front.sv @@
// front end: accepts input words and classifies each character into a token
module itp_front (
    input  logic              i_in_valid,
    input  itp_pkg::t_in_word i_in_word,
    input  logic              i_q_full,
    output logic              o_in_stall,
    output logic              o_push,
    output itp_pkg::t_token   o_token
);
    import itp_pkg::*;

    logic       is_digit;
    logic       is_upper;
    logic       is_lower;
    logic [7:0] sym;

    assign sym = i_in_word.symbol;

    // accept whenever the queue has room
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // character ranges
    assign is_digit = (sym >= 8'h30) && (sym <= 8'h39);
    assign is_upper = (sym >= 8'h41) && (sym <= 8'h5A);
    assign is_lower = (sym >= 8'h61) && (sym <= 8'h7A);

    // token classification
    always_comb begin
        o_token.symbol = sym;
        o_token.last   = i_in_word.expr_last;
        if (is_digit || is_upper || is_lower) begin
            o_token.kind = TK_ALNUM;
        end else if (sym == CH_OPEN) begin
            o_token.kind = TK_OPEN;
        end else if (sym == CH_CLOSE) begin
            o_token.kind = TK_CLOSE;
        end else if (prio_of(sym) != 3'd0) begin
            o_token.kind = TK_OPER;
        end else begin
            o_token.kind = TK_UNKNOWN;
        end
    end

endmodule

@@ rtl/core/itp_queue.sv @@
// two entry token queue between front and back ends
module itp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  itp_pkg::t_token i_token,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output itp_pkg::t_token o_token
);
    import itp_pkg::*;

    t_token     r_slot [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_fill, n_fill;
    logic       do_pop;

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_token = r_slot[r_rptr];
    assign do_pop  = i_pop && o_valid;

    // pointer and fill update
    always_comb begin
        n_wptr = i_push ? ~r_wptr : r_wptr;
        n_rptr = do_pop ? ~r_rptr : r_rptr;
        n_fill = r_fill;
        if (i_push && !do_pop) begin
            n_fill = r_fill + 2'd1;
        end else if (!i_push && do_pop) begin
            n_fill = r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_fill <= n_fill;
        end
    end

    // token storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_token;
        end
    end

endmodule

@@ rtl/core/itp_back.sv @@
// back end: operator stack sequencer, result hold slot and output register
module itp_back #(
    parameter int STACK_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  itp_pkg::t_token    i_q_token,
    output logic               o_q_pop,
    output logic               o_out_valid,
    output itp_pkg::t_out_word o_out_word,
    input  logic               i_out_stall
);
    import itp_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    t_back_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_disc, n_disc;
    t_token        r_tok;
    t_out_word     r_pend, n_pend;
    logic          r_pend_valid, n_pend_valid;
    t_out_word     r_out, n_out;
    logic          r_out_valid, n_out_valid;

    logic          emit_v;
    logic          fin_v;
    t_out_word     emit_word;
    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    top_sym;
    logic [CW-1:0] cnt_m1;
    logic          stack_full;
    logic          stack_empty;
    logic          can_load;
    logic          emit_ok;
    logic          finish_ok;
    logic          top_is_open;
    logic          top_pops;

    // operator stack memory
    itp_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_tok.symbol),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (top_sym)
    );

    // stack status and flow conditions
    assign cnt_m1      = r_count - CW'(1);
    assign ram_waddr   = r_count[AW-1:0];
    assign ram_raddr   = cnt_m1[AW-1:0];
    assign stack_full  = (r_count == CW'(STACK_DEPTH));
    assign stack_empty = (r_count == '0);
    assign can_load    = !r_out_valid || !i_out_stall;
    assign emit_ok     = !r_pend_valid || can_load;
    assign finish_ok   = can_load || (!r_pend_valid && !r_tok.last);
    assign top_is_open = (top_sym == CH_OPEN);
    assign top_pops    = pops_over(top_sym, r_tok.symbol);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (r_disc) begin
                    n_state = S_END;
                end else begin
                    unique case (r_tok.kind)
                        TK_ALNUM: begin
                            if (emit_ok) n_state = r_tok.last ? S_FLUSH : S_END;
                        end
                        TK_OPEN: begin
                            if (stack_full) begin
                                if (emit_ok) n_state = S_END;
                            end else begin
                                n_state = r_tok.last ? S_FLUSH : S_END;
                            end
                        end
                        TK_CLOSE: begin
                            if (stack_empty) begin
                                if (emit_ok) n_state = S_END;
                            end else begin
                                n_state = S_TOP;
                            end
                        end
                        TK_OPER: begin
                            if (stack_empty) begin
                                n_state = r_tok.last ? S_FLUSH : S_END;
                            end else begin
                                n_state = S_TOP;
                            end
                        end
                        default: begin
                            if (emit_ok) n_state = S_END;
                        end
                    endcase
                end
            end
            S_TOP: begin
                if (r_tok.kind == TK_CLOSE) begin
                    if (top_is_open) begin
                        n_state = r_tok.last ? S_FLUSH : S_END;
                    end else if (emit_ok) begin
                        n_state = S_EXEC;
                    end
                end else if (top_pops) begin
                    if (emit_ok) n_state = S_EXEC;
                end else if (stack_full) begin
                    if (emit_ok) n_state = S_END;
                end else begin
                    n_state = r_tok.last ? S_FLUSH : S_END;
                end
            end
            S_FLUSH: begin
                n_state = stack_empty ? S_END : S_FTOP;
            end
            S_FTOP: begin
                if (emit_ok) n_state = top_is_open ? S_END : S_FLUSH;
            end
            S_END: begin
                if (finish_ok) n_state = i_q_valid ? S_EXEC : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: stack access, result emission, queue pop
    always_comb begin
        emit_v    = 1'b0;
        emit_word = '0;
        fin_v     = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        n_count   = r_count;
        n_disc    = r_disc;
        o_q_pop   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_q_pop = i_q_valid;
            end
            S_EXEC: begin
                if (!r_disc) begin
                    unique case (r_tok.kind)
                        TK_ALNUM: begin
                            if (emit_ok) begin
                                emit_v             = 1'b1;
                                emit_word.out_char = r_tok.symbol;
                                emit_word.has_char = 1'b1;
                            end
                        end
                        TK_OPEN: begin
                            if (stack_full) begin
                                if (emit_ok) begin
                                    emit_v               = 1'b1;
                                    emit_word.error_code = ERR_OVERFLOW;
                                    n_count              = '0;
                                    n_disc               = 1'b1;
                                end
                            end else begin
                                ram_we  = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        TK_CLOSE: begin
                            if (stack_empty) begin
                                if (emit_ok) begin
                                    emit_v               = 1'b1;
                                    emit_word.error_code = ERR_UNMATCHED;
                                    n_count              = '0;
                                    n_disc               = 1'b1;
                                end
                            end else begin
                                ram_re = 1'b1;
                            end
                        end
                        TK_OPER: begin
                            if (stack_empty) begin
                                ram_we  = 1'b1;
                                n_count = r_count + CW'(1);
                            end else begin
                                ram_re = 1'b1;
                            end
                        end
                        default: begin
                            if (emit_ok) begin
                                emit_v               = 1'b1;
                                emit_word.error_code = ERR_UNKNOWN;
                                n_count              = '0;
                                n_disc               = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_TOP: begin
                if (r_tok.kind == TK_CLOSE) begin
                    if (top_is_open) begin
                        n_count = cnt_m1;
                    end else if (emit_ok) begin
                        emit_v             = 1'b1;
                        emit_word.out_char = top_sym;
                        emit_word.has_char = 1'b1;
                        n_count            = cnt_m1;
                    end
                end else if (top_pops) begin
                    if (emit_ok) begin
                        emit_v             = 1'b1;
                        emit_word.out_char = top_sym;
                        emit_word.has_char = 1'b1;
                        n_count            = cnt_m1;
                    end
                end else if (stack_full) begin
                    if (emit_ok) begin
                        emit_v               = 1'b1;
                        emit_word.error_code = ERR_OVERFLOW;
                        n_count              = '0;
                        n_disc               = 1'b1;
                    end
                end else begin
                    ram_we  = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            S_FLUSH: begin
                ram_re = !stack_empty;
            end
            S_FTOP: begin
                if (emit_ok) begin
                    emit_v = 1'b1;
                    if (top_is_open) begin
                        emit_word.error_code = ERR_UNMATCHED;
                        n_count              = '0;
                        n_disc               = 1'b1;
                    end else begin
                        emit_word.out_char = top_sym;
                        emit_word.has_char = 1'b1;
                        n_count            = cnt_m1;
                    end
                end
            end
            S_END: begin
                if (finish_ok) begin
                    fin_v   = 1'b1;
                    o_q_pop = i_q_valid;
                    if (r_tok.last) begin
                        n_disc  = 1'b0;
                        n_count = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    // hold slot keeps one result back so the last one of a word can be marked
    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        if (emit_v) begin
            if (r_pend_valid) begin
                n_out       = r_pend;
                n_out_valid = 1'b1;
            end
            n_pend       = emit_word;
            n_pend_valid = 1'b1;
        end else if (fin_v) begin
            if (r_pend_valid) begin
                n_out           = r_pend;
                n_out.run_last  = 1'b1;
                n_out.expr_done = r_tok.last;
                n_out_valid     = 1'b1;
                n_pend_valid    = 1'b0;
            end else if (r_tok.last) begin
                n_out           = '0;
                n_out.run_last  = 1'b1;
                n_out.expr_done = 1'b1;
                n_out_valid     = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_disc       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_disc       <= n_disc;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_tok <= i_q_token;
        end
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

@@ rtl/core/infix_to_postfix_converter_core.sv @@
// top level of the shunting-yard infix to postfix converter
// Takes one ASCII character per input word and returns postfix characters, with run_last on
// the last result of each input word and expr_done on the final result of the expression.
// A front end classifies characters into a two-word queue, so input keeps flowing while the
// back end sequencer works on the operator stack, until the queue fills. In the back end
// a letter, a digit or a push passes through EXEC and END; every operator popped from the
// stack takes a stack memory read with registered data, then the emit, and an operator or
// close paren that reads a top it does not emit still spends a step on that read. The last
// word adds a read and an emit per flushed entry plus a final check in FLUSH, and a word
// that finds the back end idle is first taken from the queue in IDLE. The stack needs no
// clearing after reset; entries above the count are never read.
module infix_to_postfix_converter_core #(
    parameter int STACK_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  itp_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output itp_pkg::t_out_word o_out_word
);
    import itp_pkg::*;

    logic   q_push;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;
    t_token f_token;
    t_token q_token;

    // classify incoming characters
    itp_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (q_push),
        .o_token    (f_token)
    );

    // decoupling queue
    itp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_token (f_token),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_token (q_token)
    );

    // stack sequencer and output
    itp_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_token   (q_token),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

endmodule

@@ rtl/core/itp_checker.sv @@
// port level checks for the infix to postfix converter, bound to the top level
module itp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input itp_pkg::t_out_word o_out_word
);
    import itp_pkg::*;

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    // the end of an expression is also the end of its input word
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.expr_done |-> o_out_word.run_last)
        else $error("expr_done without run_last");

    // a character result never carries an error
    a_char_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.has_char |-> o_out_word.error_code == ERR_NONE)
        else $error("character result with error code");

    // markers and errors carry a zero character
    a_bare_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.has_char |-> o_out_word.out_char == 8'h00)
        else $error("bare result with nonzero character");

    // an error ends the results of its input word
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.error_code != ERR_NONE |-> o_out_word.run_last)
        else $error("error result not last of its word");

endmodule

bind infix_to_postfix_converter_core itp_checker u_itp_checker (.*);

@@ tb/sv/infix_to_postfix_converter_core_tb.sv @@
// self-checking testbench for the infix to postfix converter core
`timescale 1ns / 100ps

module infix_to_postfix_converter_core_tb;
    import itp_pkg::*;

    localparam int STACK_DEPTH    = 32;
    localparam int ITEM_GOAL      = 400;
    localparam int QUIET_TAIL     = 330;
    localparam int PRESSURE_AT    = 150;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 150;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_CAP      = 100;

    // postfix predictor and store of the words still to come
    class postfix_scoreboard;
        logic [7:0]  op_stack [STACK_DEPTH];
        int unsigned op_count;
        bit          dropping;
        t_out_word   postfix_q[$];
        t_out_word   run_q[$];
        int          errors;
        int          live_items;

        function new();
            op_count   = 0;
            dropping   = 1'b0;
            errors     = 0;
            live_items = 0;
        endfunction

        // one line per mismatch, printing capped so a dead block cannot flood the log
        task report(string msg);
            errors++;
            if (errors <= PRINT_CAP) begin
                $display("%0t mismatch: %s", $time, msg);
            end
        endtask

        function int unsigned rank(logic [7:0] c);
            case (c)
                CH_OPEN:                       return 1;
                CH_PLUS, CH_MINUS:             return 2;
                CH_STAR, CH_SLASH, CH_PERCENT: return 3;
                CH_CARET:                      return 4;
                default:                       return 0;
            endcase
        endfunction

        function bit is_alnum(logic [7:0] c);
            return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        endfunction

        // caret is right-associative, so it never pops another caret
        function bit leaves_before(logic [7:0] top, logic [7:0] tok);
            if (top == CH_CARET && tok == CH_CARET) begin
                return 1'b0;
            end
            return rank(top) >= rank(tok);
        endfunction

        function void emit(logic [7:0] ch, logic has, logic [1:0] err);
            t_out_word w;
            w.out_char   = ch;
            w.has_char   = has;
            w.run_last   = 1'b0;
            w.expr_done  = 1'b0;
            w.error_code = err;
            run_q.push_back(w);
        endfunction

        function void raise_error(logic [1:0] err);
            emit(8'h00, 1'b0, err);
            op_count = 0;
            dropping = 1'b1;
        endfunction

        function void push_op(logic [7:0] c);
            if (op_count >= STACK_DEPTH) begin
                raise_error(ERR_OVERFLOW);
            end else begin
                op_stack[op_count] = c;
                op_count++;
            end
        endfunction

        function logic [7:0] pop_op();
            op_count--;
            return op_stack[op_count];
        endfunction

        // work out the postfix words caused by one accepted input word
        function void note_symbol(t_in_word in_w);
            logic [7:0] c;
            logic [7:0] t;
            bit         fin;
            t_out_word  w;
            c   = in_w.symbol;
            fin = in_w.expr_last;
            run_q.delete();

            if (!dropping) begin
                live_items++;
                if (is_alnum(c)) begin
                    emit(c, 1'b1, ERR_NONE);
                end else if (c == CH_OPEN) begin
                    push_op(c);
                end else if (c == CH_CLOSE) begin
                    while (1'b1) begin
                        if (op_count == 0) begin
                            raise_error(ERR_UNMATCHED);
                            break;
                        end
                        t = pop_op();
                        if (t == CH_OPEN) begin
                            break;
                        end
                        emit(t, 1'b1, ERR_NONE);
                    end
                end else if (rank(c) != 0) begin
                    while (op_count > 0 && leaves_before(op_stack[op_count-1], c)) begin
                        emit(pop_op(), 1'b1, ERR_NONE);
                    end
                    push_op(c);
                end else begin
                    raise_error(ERR_UNKNOWN);
                end
            end

            // end of expression: flush, an open paren left over is an error
            if (fin) begin
                if (!dropping) begin
                    while (op_count > 0) begin
                        t = pop_op();
                        if (t == CH_OPEN) begin
                            raise_error(ERR_UNMATCHED);
                            break;
                        end
                        emit(t, 1'b1, ERR_NONE);
                    end
                end
                if (run_q.size() == 0) begin
                    emit(8'h00, 1'b0, ERR_NONE);
                end
                dropping = 1'b0;
                op_count = 0;
            end

            // tag the last word of this run
            if (run_q.size() > 0) begin
                w = run_q.pop_back();
                w.run_last = 1'b1;
                if (fin) begin
                    w.expr_done = 1'b1;
                end
                run_q.push_back(w);
            end
            foreach (run_q[i]) begin
                postfix_q.push_back(run_q[i]);
            end
        endfunction

        // compare one accepted output word with the oldest prediction
        task check_postfix(t_out_word got);
            t_out_word want;
            if (postfix_q.size() == 0) begin
                report($sformatf("unexpected word char=%02h has=%0b err=%0d",
                                 got.out_char, got.has_char, got.error_code));
                return;
            end
            want = postfix_q.pop_front();
            if (got.out_char !== want.out_char) begin
                report($sformatf("out_char %02h, want %02h", got.out_char, want.out_char));
            end
            if (got.has_char !== want.has_char) begin
                report($sformatf("has_char %0b, want %0b", got.has_char, want.has_char));
            end
            if (got.run_last !== want.run_last) begin
                report($sformatf("run_last %0b, want %0b", got.run_last, want.run_last));
            end
            if (got.expr_done !== want.expr_done) begin
                report($sformatf("expr_done %0b, want %0b", got.expr_done, want.expr_done));
            end
            if (got.error_code !== want.error_code) begin
                report($sformatf("error_code %0d, want %0d", got.error_code, want.error_code));
            end
        endtask

        task finish_check();
            if (postfix_q.size() != 0) begin
                report($sformatf("%0d postfix words never arrived", postfix_q.size()));
            end
        endtask
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_word   i_in_word;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_word  o_out_word;

    postfix_scoreboard sb = new();
    bit         idling_on = 1'b1;
    bit         hold_req  = 1'b0;
    logic [7:0] sym_q[$];
    int         quiet_cycles = 0;

    infix_to_postfix_converter_core #(
        .STACK_DEPTH(STACK_DEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // handshake monitors
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.note_symbol(i_in_word);
            end
            if (o_out_valid && !i_out_stall) begin
                sb.check_postfix(o_out_word);
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // output side: random stall bursts plus one long hold-off on request
    initial begin : out_side
        int n;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 11);
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // offer one word and hold it until taken
    task automatic send_word(input logic [7:0] sym, input logic fin);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_in_word.symbol    <= sym;
        i_in_word.expr_last <= fin;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_word(s[i], i == s.len() - 1);
        end
    endtask

    task automatic send_symbols();
        for (int i = 0; i < sym_q.size(); i++) begin
            send_word(sym_q[i], i == sym_q.size() - 1);
        end
    endtask

    // random bytes with random end flags, closed by a last word
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            send_word(8'($urandom_range(0, 255)), (i == n - 1) || ($urandom_range(0, 3) == 0));
        end
    endtask

    function automatic logic [7:0] rand_alnum();
        int unsigned r;
        r = $urandom_range(0, 61);
        if (r < 10) begin
            return "0" + 8'(r);
        end else if (r < 36) begin
            return "A" + 8'(r - 10);
        end
        return "a" + 8'(r - 36);
    endfunction

    function automatic logic [7:0] rand_op();
        case ($urandom_range(0, 5))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            3:       return CH_SLASH;
            4:       return CH_PERCENT;
            default: return CH_CARET;
        endcase
    endfunction

    // well-formed infix expression of roughly max_len characters
    function automatic void build_expr(input int max_len);
        int open_n;
        bit want_operand;
        open_n       = 0;
        want_operand = 1'b1;
        while (1'b1) begin
            if (want_operand) begin
                if (sym_q.size() < max_len && $urandom_range(0, 3) == 0) begin
                    sym_q.push_back(CH_OPEN);
                    open_n++;
                end else begin
                    sym_q.push_back(rand_alnum());
                    want_operand = 1'b0;
                end
            end else if (open_n > 0 && $urandom_range(0, 2) == 0) begin
                sym_q.push_back(CH_CLOSE);
                open_n--;
            end else if (sym_q.size() >= max_len) begin
                break;
            end else begin
                sym_q.push_back(rand_op());
                want_operand = 1'b1;
            end
        end
        repeat (open_n) sym_q.push_back(CH_CLOSE);
    endfunction

    // deep nesting around the stack depth, overflowing some of the time
    function automatic void build_nest();
        int n;
        n = $urandom_range(20, 34);
        repeat (n) begin
            if ($urandom_range(0, 3) == 0) begin
                sym_q.push_back(rand_alnum());
                sym_q.push_back(rand_op());
            end
            sym_q.push_back(CH_OPEN);
        end
        sym_q.push_back(rand_alnum());
        repeat (n) begin
            sym_q.push_back(CH_CLOSE);
            if ($urandom_range(0, 3) == 0) begin
                sym_q.push_back(rand_op());
                sym_q.push_back(rand_alnum());
            end
        end
    endfunction

    // break one spot of the expression
    function automatic void corrupt();
        int unsigned k;
        k = $urandom_range(0, sym_q.size() - 1);
        case ($urandom_range(0, 3))
            0:       sym_q[k] = 8'($urandom_range(0, 255));
            1:       sym_q.delete(k);
            2:       sym_q.insert(k, CH_CLOSE);
            default: sym_q.insert(k, CH_OPEN);
        endcase
        if (sym_q.size() == 0) begin
            sym_q.push_back(rand_alnum());
        end
    endfunction

    // main stimulus
    initial begin
        int  r;
        bit  pressure_done;
        pressure_done = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_word   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, every operator, error and marker cases
        send_text("0+Z*a");
        send_text("(9^A^z)%b/A");
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b0);
        send_text("y");
        send_text("a-)b");
        send_text("(");
        send_text("()");

        // random expressions, mostly well formed
        while (sb.live_items < ITEM_GOAL) begin
            if (sb.live_items >= QUIET_TAIL) begin
                idling_on = 1'b0;
            end else begin
                idling_on = ($urandom_range(0, 3) != 0);
            end
            sym_q.delete();
            if (!pressure_done && sb.live_items >= PRESSURE_AT) begin
                // output held off while a long expression keeps coming
                pressure_done = 1'b1;
                hold_req      = 1'b1;
                sym_q.push_back(rand_alnum());
                repeat (20) begin
                    sym_q.push_back(rand_op());
                    sym_q.push_back(rand_alnum());
                end
                send_symbols();
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    build_expr($urandom_range(1, 16));
                    send_symbols();
                end else if (r < 75) begin
                    build_expr($urandom_range(1, 16));
                    corrupt();
                    send_symbols();
                end else if (r < 87) begin
                    build_nest();
                    send_symbols();
                end else begin
                    send_noise();
                end
            end
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.postfix_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.finish_check();
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/itp_pkg.sv
rtl/core/itp_ram.sv
rtl/core/itp_front.sv
rtl/core/itp_queue.sv
rtl/core/itp_back.sv
rtl/core/infix_to_postfix_converter_core.sv
rtl/core/itp_checker.sv
tb/sv/infix_to_postfix_converter_core_tb.sv
